>>> rtl/fpe_pkg.sv
// Shared definitions for the Forth primitive executor.
// Holds the primitive codes, the state encodings and the memory request struct.
// No dependencies.
`default_nettype none

package fpe_pkg;

    // Primitive codes carried on the input channel's tuser.
    typedef enum logic [4:0] {
        OP_BYE      = 5'd0,
        OP_DOCOL    = 5'd1,
        OP_EXIT     = 5'd2,
        OP_EXECUTE  = 5'd3,
        OP_BRANCH   = 5'd4,
        OP_QBRANCH  = 5'd5,
        OP_SP_FETCH = 5'd6,
        OP_SP_STORE = 5'd7,
        OP_LIT      = 5'd8,
        OP_DUP      = 5'd9,
        OP_DROP     = 5'd10,
        OP_SWAP     = 5'd11,
        OP_OVER     = 5'd12,
        OP_RP_FETCH = 5'd13,
        OP_RP_STORE = 5'd14,
        OP_TO_R     = 5'd15,
        OP_R_FETCH  = 5'd16,
        OP_R_FROM   = 5'd17,
        OP_STORE    = 5'd18,
        OP_FETCH    = 5'd19,
        OP_CSTORE   = 5'd20,
        OP_CFETCH   = 5'd21,
        OP_ADD      = 5'd22,
        OP_AND      = 5'd23,
        OP_OR       = 5'd24,
        OP_XOR      = 5'd25,
        OP_ZLESS    = 5'd26
    } op_t;

    // Sequencer states of the core.
    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_EXEC = 4'b0010,
        T_MEM  = 4'b0100,
        T_OUT  = 4'b1000
    } core_state_t;

    // Sequencer states of the byte memory unit.
    typedef enum logic [3:0] {
        M_IDLE   = 4'b0001,
        M_MOD    = 4'b0010,
        M_ACCESS = 4'b0100,
        M_DONE   = 4'b1000
    } mem_state_t;

    // Request from the core to the byte memory unit.
    typedef struct packed {
        logic start;
        logic store;
        logic whole_cell;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/fpe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both stacks and the byte memory. No dependencies.
`default_nettype none

module fpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/fpe_mem.sv
// Byte memory unit: reduces a cell address modulo the memory size and moves
// one byte per cycle for cell and byte loads and stores. Uses fpe_pkg, fpe_ram.
`default_nettype none

module fpe_mem #(
    parameter int MEM_BYTES = 4096,
    parameter int CELL_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpe_pkg::mem_req_t    req,
    input  wire logic [CELL_BITS-1:0] addr,
    input  wire logic [CELL_BITS-1:0] wdata,
    output logic                      done,
    output logic      [CELL_BITS-1:0] rdata
);
    import fpe_pkg::*;

    localparam int CellBytes = (CELL_BITS + 7) / 8;
    localparam int BufBits   = CellBytes * 8;
    localparam int MemAw     = $clog2(MEM_BYTES);
    localparam int KW        = $clog2(CellBytes + 2);
    localparam int RedBits   = MemAw + 8;
    localparam bit MemPow2   = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
    // Rounded-up reciprocal of the memory size, exact for partial remainders.
    localparam logic [RedBits:0] Recip = (RedBits+1)'(
        ((64'd1 << (RedBits + MemAw)) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));

    mem_state_t          state_reg, state_next;
    logic                store_reg, store_next;
    logic                cell_reg, cell_next;
    logic [BufBits-1:0]  src_reg, src_next;
    logic [MemAw-1:0]    rem_reg, rem_next;
    logic [7:0]          quo_reg, quo_next;
    logic                phase_reg, phase_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    logic [MemAw-1:0]    baddr_reg, baddr_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [BufBits-1:0]  buf_reg, buf_next;

    logic [RedBits-1:0]  red_x;
    logic [2*RedBits:0]  red_prod;
    logic [RedBits-1:0]  red_rem;
    logic [KW-1:0]       nbytes;
    logic [MemAw-1:0]    baddr_inc;
    logic                ram_we, ram_re;
    logic [7:0]          ram_q;
    logic [BufBits+CELL_BITS-1:0] wdata_wide;

    // One byte of the address reduction: the quotient comes from a reciprocal
    // multiply in the first phase, the remainder from a subtract in the second.
    assign red_x    = {rem_reg, src_reg[BufBits-1 -: 8]};
    assign red_prod = red_x * Recip;
    assign red_rem  = red_x - RedBits'(quo_reg) * RedBits'(MEM_BYTES);

    assign nbytes     = cell_reg ? KW'(CellBytes) : KW'(1);
    assign baddr_inc  = (baddr_reg == MemAw'(MEM_BYTES - 1)) ? '0 : baddr_reg + MemAw'(1);
    assign wdata_wide = {{BufBits{1'b0}}, wdata};

    // Sequencer for reduction and byte transfers.
    always_comb begin
        state_next = state_reg;
        store_next = store_reg;
        cell_next  = cell_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        baddr_next = baddr_reg;
        k_next     = k_reg;
        buf_next   = buf_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    store_next = req.store;
                    cell_next  = req.whole_cell;
                    src_next   = BufBits'(addr);
                    rem_next   = '0;
                    quo_next   = '0;
                    phase_next = 1'b0;
                    cnt_next   = KW'(CellBytes - 1);
                    k_next     = '0;
                    buf_next   = wdata_wide[BufBits-1:0];
                    baddr_next = addr[MemAw-1:0];
                    state_next = MemPow2 ? M_ACCESS : M_MOD;
                end
            end
            M_MOD: begin
                if (!phase_reg) begin
                    quo_next   = red_prod[2*RedBits-1 -: 8];
                    phase_next = 1'b1;
                end else begin
                    rem_next   = red_rem[MemAw-1:0];
                    src_next   = src_reg << 8;
                    cnt_next   = cnt_reg - KW'(1);
                    phase_next = 1'b0;
                    if (cnt_reg == '0) begin
                        baddr_next = red_rem[MemAw-1:0];
                        state_next = M_ACCESS;
                    end
                end
            end
            M_ACCESS: begin
                k_next = k_reg + KW'(1);
                if (store_reg) begin
                    // Write the low byte, then move to the next one.
                    ram_we     = 1'b1;
                    buf_next   = buf_reg >> 8;
                    baddr_next = baddr_inc;
                    if (k_reg == nbytes - KW'(1)) begin
                        state_next = M_DONE;
                    end
                end else begin
                    // Issue a read each cycle and collect the previous one.
                    ram_re = k_reg < nbytes;
                    if (k_reg != '0) begin
                        buf_next = {ram_q, buf_reg[BufBits-1:8]};
                    end
                    if (ram_re) begin
                        baddr_next = baddr_inc;
                    end
                    if (k_reg == nbytes) begin
                        state_next = M_DONE;
                    end
                end
            end
            M_DONE: begin
                state_next = M_IDLE;
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
        store_reg <= store_next;
        cell_reg  <= cell_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        baddr_reg <= baddr_next;
        k_reg     <= k_next;
        buf_reg   <= buf_next;
    end

    fpe_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_bytes (
        .clk  (clk),
        .we   (ram_we),
        .waddr(baddr_reg),
        .wdata(buf_reg[7:0]),
        .re   (ram_re),
        .raddr(baddr_reg),
        .rdata(ram_q)
    );

    // A cell load fills the buffer from the top; a byte load leaves its byte on top.
    assign done  = state_reg == M_DONE;
    assign rdata = cell_reg ? buf_reg[CELL_BITS-1:0]
                            : CELL_BITS'(buf_reg[BufBits-1 -: 8]);

endmodule

`default_nettype wire

>>> rtl/forth_primitive_executor_core.sv
// Top level of the Forth primitive executor: sequencer, stacks and result register.
// Uses fpe_pkg, fpe_ram and fpe_mem.
//
// Executes one threaded-code primitive per request. A request is taken in the
// idle state, which reads the stack RAMs; the next cycle updates the stacks,
// the instruction pointer and the top-of-stack register and loads the result
// register if it is free, and the next request is taken while the result
// waits in the output register. The stack RAMs have a registered read and
// each request reads them once. Memory primitives go through the byte memory
// one byte per cycle; when MEM_BYTES is not a power of two the address is
// first reduced modulo MEM_BYTES one address byte at a time. A config write
// loads start_address into the instruction pointer and must only happen while
// the block is idle. After bye, every further request returns the held state
// with stopped set.
`default_nettype none

module forth_primitive_executor_core #(
    parameter int STACK_DEPTH = 16,
    parameter int MEM_BYTES   = 4096,
    parameter int CELL_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // word_address[15:0], inline_cell[47:16]
    input  wire logic [4:0]  s_tuser,   // op[4:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // next_address[15:0], top_value[47:16],
                                        // stopped[48], stack_fault[49], zero[55:50]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import fpe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    core_state_t          state_reg, state_next;
    op_t                  op_reg;
    logic [15:0]          wa_reg;
    logic [31:0]          inl_reg;
    logic [15:0]          ip_reg;
    logic [CELL_BITS-1:0] top_reg;
    logic [DW-1:0]        dd_reg, rd_reg;
    logic                 halt_reg, fault_reg;
    logic                 m_tvalid_reg;
    logic [55:0]          m_tdata_reg;

    logic                 accept, out_free;
    op_t                  in_op;
    logic [DW-1:0]        clamp_top;
    logic [CELL_BITS-1:0] dq1, dq2, rq;
    logic [AW-1:0]        rd_a, rd_b, rd_r;

    // Next-state values of the executing primitive.
    logic [15:0]          after, ip_n;
    logic [CELL_BITS-1:0] t_n, d_pop, r_pop, lit_val;
    logic [DW-1:0]        dd_n, rd_n, dd_push;
    logic                 halt_n, flt;
    logic                 push_d, pop_d, push_r, pop_r;
    logic                 d_empty, d_full, r_empty, r_full;
    logic                 dwe, rwe;
    logic [AW-1:0]        dwa, rwa;
    logic [CELL_BITS-1:0] dwd, rwd;
    mem_req_t             mreq;
    logic [CELL_BITS-1:0] mem_data, mem_rdata;
    logic                 mem_done, is_fetch;
    logic [CELL_BITS-1:0] res_top;
    logic [CELL_BITS+31:0] res_top_wide;

    assign in_op     = op_t'(s_tuser);
    assign s_tready  = state_reg == T_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Stack read addresses are issued when a request is taken.
    assign clamp_top = (top_reg > CELL_BITS'(STACK_DEPTH)) ? DW'(STACK_DEPTH)
                                                          : top_reg[DW-1:0];
    always_comb begin
        rd_a = dd_reg[AW-1:0] - AW'(1);
        rd_r = rd_reg[AW-1:0] - AW'(1);
        rd_b = (in_op == OP_SP_STORE) ? clamp_top[AW-1:0] - AW'(1)
                                      : dd_reg[AW-1:0] - AW'(2);
    end

    assign d_empty = dd_reg == '0;
    assign d_full  = dd_reg == DW'(STACK_DEPTH);
    assign r_empty = rd_reg == '0;
    assign r_full  = rd_reg == DW'(STACK_DEPTH);
    assign d_pop   = d_empty ? '0 : dq1;
    assign r_pop   = r_empty ? '0 : rq;
    assign dd_push = d_full ? dd_reg : dd_reg + DW'(1);
    assign after   = ip_reg + 16'd1;
    assign lit_val = CELL_BITS'($signed(inl_reg));

    // Primitive semantics for the executing request.
    always_comb begin
        ip_n     = after;
        t_n      = top_reg;
        dd_n     = dd_reg;
        rd_n     = rd_reg;
        halt_n   = halt_reg;
        flt      = 1'b0;
        push_d   = 1'b0;
        pop_d    = 1'b0;
        push_r   = 1'b0;
        pop_r    = 1'b0;
        dwe      = 1'b0;
        dwa      = dd_reg[AW-1:0];
        dwd      = top_reg;
        rwe      = 1'b0;
        rwa      = rd_reg[AW-1:0];
        rwd      = top_reg;
        mreq     = '0;
        mem_data = d_pop;
        if (halt_reg) begin
            ip_n = ip_reg;
        end else begin
            case (op_reg)
                OP_BYE: begin
                    halt_n = 1'b1;
                end
                OP_DOCOL: begin
                    push_r = 1'b1;
                    rwd    = CELL_BITS'(after);
                    ip_n   = wa_reg + 16'd1;
                end
                OP_EXIT: begin
                    pop_r = 1'b1;
                    ip_n  = r_pop[15:0];
                end
                OP_EXECUTE: begin
                    t_n    = d_pop;
                    pop_d  = 1'b1;
                    push_r = 1'b1;
                    rwd    = CELL_BITS'(after);
                    ip_n   = top_reg[15:0] + 16'd1;
                end
                OP_BRANCH: begin
                    ip_n = after + inl_reg[15:0];
                end
                OP_QBRANCH: begin
                    t_n   = d_pop;
                    pop_d = 1'b1;
                    ip_n  = (top_reg == '0) ? after + inl_reg[15:0] : after + 16'd1;
                end
                OP_SP_FETCH: begin
                    push_d = 1'b1;
                    t_n    = CELL_BITS'(dd_push);
                end
                OP_SP_STORE: begin
                    if (clamp_top == '0) begin
                        flt  = 1'b1;
                        t_n  = '0;
                        dd_n = '0;
                    end else begin
                        t_n  = dq2;
                        dd_n = clamp_top - DW'(1);
                    end
                end
                OP_LIT: begin
                    push_d = 1'b1;
                    t_n    = lit_val;
                    ip_n   = after + 16'd1;
                end
                OP_DUP: begin
                    push_d = 1'b1;
                end
                OP_DROP: begin
                    t_n   = d_pop;
                    pop_d = 1'b1;
                end
                OP_SWAP: begin
                    if (d_empty) begin
                        flt = 1'b1;
                    end else begin
                        dwe = 1'b1;
                        dwa = dd_reg[AW-1:0] - AW'(1);
                        t_n = dq1;
                    end
                end
                OP_OVER: begin
                    flt    = d_empty;
                    t_n    = d_pop;
                    push_d = 1'b1;
                end
                OP_RP_FETCH: begin
                    push_d = 1'b1;
                    t_n    = CELL_BITS'(rd_reg);
                end
                OP_RP_STORE: begin
                    rd_n  = clamp_top;
                    t_n   = d_pop;
                    pop_d = 1'b1;
                end
                OP_TO_R: begin
                    push_r = 1'b1;
                    t_n    = d_pop;
                    pop_d  = 1'b1;
                end
                OP_R_FETCH: begin
                    push_d = 1'b1;
                    flt    = r_empty;
                    t_n    = r_pop;
                end
                OP_R_FROM: begin
                    push_d = 1'b1;
                    t_n    = r_pop;
                    pop_r  = 1'b1;
                end
                OP_STORE, OP_CSTORE: begin
                    // Pop the value, then the new top; the old top is the address.
                    mreq.start      = 1'b1;
                    mreq.store      = 1'b1;
                    mreq.whole_cell = op_reg == OP_STORE;
                    if (dd_reg < DW'(2)) begin
                        flt  = 1'b1;
                        t_n  = '0;
                        dd_n = '0;
                    end else begin
                        t_n  = dq2;
                        dd_n = dd_reg - DW'(2);
                    end
                end
                OP_FETCH, OP_CFETCH: begin
                    mreq.start      = 1'b1;
                    mreq.whole_cell = op_reg == OP_FETCH;
                end
                OP_ADD: begin
                    t_n   = d_pop + top_reg;
                    pop_d = 1'b1;
                end
                OP_AND: begin
                    t_n   = d_pop & top_reg;
                    pop_d = 1'b1;
                end
                OP_OR: begin
                    t_n   = d_pop | top_reg;
                    pop_d = 1'b1;
                end
                OP_XOR: begin
                    t_n   = d_pop ^ top_reg;
                    pop_d = 1'b1;
                end
                OP_ZLESS: begin
                    t_n = top_reg[CELL_BITS-1] ? '1 : '0;
                end
                default: begin
                end
            endcase

            // Common push and pop bookkeeping; a full push or empty pop faults.
            if (push_d) begin
                if (d_full) begin
                    flt = 1'b1;
                end else begin
                    dwe  = 1'b1;
                    dd_n = dd_reg + DW'(1);
                end
            end
            if (pop_d) begin
                if (d_empty) begin
                    flt = 1'b1;
                end else begin
                    dd_n = dd_reg - DW'(1);
                end
            end
            if (push_r) begin
                if (r_full) begin
                    flt = 1'b1;
                end else begin
                    rwe  = 1'b1;
                    rd_n = rd_reg + DW'(1);
                end
            end
            if (pop_r) begin
                if (r_empty) begin
                    flt = 1'b1;
                end else begin
                    rd_n = rd_reg - DW'(1);
                end
            end
        end
    end

    assign is_fetch = (op_reg == OP_FETCH) || (op_reg == OP_CFETCH);

    // Top value that goes into the result register this cycle.
    always_comb begin
        if (state_reg == T_EXEC) begin
            res_top = t_n;
        end else if (state_reg == T_MEM && is_fetch) begin
            res_top = mem_rdata;
        end else begin
            res_top = top_reg;
        end
    end
    assign res_top_wide = {32'd0, res_top};

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    state_next = T_EXEC;
                end
            end
            T_EXEC: begin
                if (mreq.start) begin
                    state_next = T_MEM;
                end else if (out_free) begin
                    state_next = T_IDLE;
                end else begin
                    state_next = T_OUT;
                end
            end
            T_MEM: begin
                if (mem_done) begin
                    state_next = out_free ? T_IDLE : T_OUT;
                end
            end
            T_OUT: begin
                if (out_free) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Architectural registers and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            ip_reg       <= '0;
            top_reg      <= '0;
            dd_reg       <= '0;
            rd_reg       <= '0;
            halt_reg     <= 1'b0;
            fault_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == T_EXEC) begin
                ip_reg    <= ip_n;
                top_reg   <= t_n;
                dd_reg    <= dd_n;
                rd_reg    <= rd_n;
                halt_reg  <= halt_n;
                fault_reg <= flt;
            end else if (cfg_valid && cfg_ready) begin
                ip_reg <= cfg_data;
            end
            if (state_reg == T_MEM && mem_done && is_fetch) begin
                top_reg <= mem_rdata;
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (((state_reg == T_EXEC) && !mreq.start && out_free) ||
                ((state_reg == T_MEM) && mem_done && out_free) ||
                ((state_reg == T_OUT) && out_free)) begin
                m_tvalid_reg <= 1'b1;
            end
        end
        if (state_reg == T_EXEC && !mreq.start && out_free) begin
            m_tdata_reg <= {6'd0, flt, halt_n, res_top_wide[31:0], ip_n};
        end else if (((state_reg == T_MEM) && mem_done && out_free) ||
                     ((state_reg == T_OUT) && out_free)) begin
            m_tdata_reg <= {6'd0, fault_reg, halt_reg, res_top_wide[31:0], ip_reg};
        end
        if (accept) begin
            op_reg  <= in_op;
            wa_reg  <= s_tdata[15:0];
            inl_reg <= s_tdata[47:16];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Data stack: two copies so that the two top entries are read at once.
    // Stack writes happen only in the execute cycle.
    fpe_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(STACK_DEPTH)
    ) u_dstack_a (
        .clk  (aclk),
        .we   (dwe && (state_reg == T_EXEC)),
        .waddr(dwa),
        .wdata(dwd),
        .re   (accept),
        .raddr(rd_a),
        .rdata(dq1)
    );

    fpe_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(STACK_DEPTH)
    ) u_dstack_b (
        .clk  (aclk),
        .we   (dwe && (state_reg == T_EXEC)),
        .waddr(dwa),
        .wdata(dwd),
        .re   (accept),
        .raddr(rd_b),
        .rdata(dq2)
    );

    fpe_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(STACK_DEPTH)
    ) u_rstack (
        .clk  (aclk),
        .we   (rwe && (state_reg == T_EXEC)),
        .waddr(rwa),
        .wdata(rwd),
        .re   (accept),
        .raddr(rd_r),
        .rdata(rq)
    );

    fpe_mem #(
        .MEM_BYTES(MEM_BYTES),
        .CELL_BITS(CELL_BITS)
    ) u_mem (
        .clk  (aclk),
        .rst_n(aresetn),
        .req  (state_reg == T_EXEC ? mreq : '0),
        .addr (top_reg),
        .wdata(mem_data),
        .done (mem_done),
        .rdata(mem_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/fpe_checker.sv
// Port-level checks for the Forth primitive executor, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fpe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The core is busy once it has taken a request, so requests are never taken back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on consecutive cycles");

    // A stopped machine never reports a stack fault.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> !m_tdata[49])
        else $error("fault reported while stopped");

endmodule

bind forth_primitive_executor_core fpe_checker u_fpe_checker (.*);

`default_nettype wire
